// File: hdl/fisr_pkg.sv
// ----------------------------------------------------------------------------
// fisr_pkg
// Shared constants and helper functions for the inverse square root pipeline.
// ----------------------------------------------------------------------------
package fisr_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned SIDE_W = 64;
  localparam int unsigned NEWTON_STEPS = 2;

  localparam logic [31:0] GUESS_MAGIC       = 32'h5f3759df;
  localparam logic [31:0] HALF_BITS         = 32'h3f000000;
  localparam logic [31:0] THREE_HALVES_BITS = 32'h3fc00000;
  localparam logic [31:0] CANON_QNAN        = 32'h7fc00000;

  function automatic logic [4:0] lzc24(input logic [23:0] m);
    logic [4:0] cnt;
    logic       found;
    cnt   = 5'd24;
    found = 1'b0;
    for (int i = 23; i >= 0; i--) begin
      if (!found && m[i]) begin
        cnt   = 5'(23 - i);
        found = 1'b1;
      end
    end
    return cnt;
  endfunction

  function automatic logic [4:0] lzc27(input logic [26:0] m);
    logic [4:0] cnt;
    logic       found;
    cnt   = 5'd27;
    found = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (!found && m[i]) begin
        cnt   = 5'(26 - i);
        found = 1'b1;
      end
    end
    return cnt;
  endfunction

  // Rounds to nearest-even and packs; a carry out of the fraction moves the
  // exponent up, which also produces infinity on overflow.
  function automatic logic [31:0] round_pack(input logic sign, input logic nan,
                                             input logic inf, input logic zero,
                                             input logic [7:0] expf,
                                             input logic [22:0] mant,
                                             input logic grd, input logic stk);
    logic [30:0] packed_v;
    logic        inc;
    logic [31:0] res;
    inc      = grd & (stk | mant[0]);
    packed_v = {expf, mant} + {30'd0, inc};
    if (nan) begin
      res = CANON_QNAN;
    end else if (inf) begin
      res = {sign, 8'hff, 23'd0};
    end else if (zero) begin
      res = {sign, 31'd0};
    end else begin
      res = {sign, packed_v};
    end
    return res;
  endfunction

endpackage

// File: hdl/fisr_fmul.sv
// ----------------------------------------------------------------------------
// fisr_fmul
// Four-stage binary32 multiplier, round to nearest-even, with a side bus.
// ----------------------------------------------------------------------------
module fisr_fmul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        ena,
  input  logic                        in_vld,
  input  logic [31:0]                 a,
  input  logic [31:0]                 b,
  input  logic [fisr_pkg::SIDE_W-1:0] side_i,
  output logic                        out_vld,
  output logic [31:0]                 res,
  output logic [fisr_pkg::SIDE_W-1:0] side_o
);

  // Stage 1: unpack and normalize subnormal operands.
  logic               a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;
  logic [23:0]        ma, mb;
  logic [4:0]         lza, lzb;
  logic               s1_vld_r;
  logic               s1_sign_r, s1_nan_r, s1_inf_r, s1_zero_r;
  logic [23:0]        s1_ma_r, s1_mb_r;
  logic signed [10:0] s1_ea_r, s1_eb_r;
  logic [fisr_pkg::SIDE_W-1:0] s1_side_r;

  assign a_nan  = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
  assign a_inf  = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
  assign a_zero = (a[30:23] == 8'h00) && (a[22:0] == 23'd0);
  assign b_nan  = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
  assign b_inf  = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
  assign b_zero = (b[30:23] == 8'h00) && (b[22:0] == 23'd0);
  assign ma     = {a[30:23] != 8'h00, a[22:0]};
  assign mb     = {b[30:23] != 8'h00, b[22:0]};
  assign lza    = fisr_pkg::lzc24(ma);
  assign lzb    = fisr_pkg::lzc24(mb);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (ena) begin
      s1_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ena) begin
      s1_sign_r <= a[31] ^ b[31];
      s1_nan_r  <= a_nan | b_nan | (a_inf & b_zero) | (a_zero & b_inf);
      s1_inf_r  <= a_inf | b_inf;
      s1_zero_r <= a_zero | b_zero;
      s1_ma_r   <= ma << lza;
      s1_mb_r   <= mb << lzb;
      s1_ea_r   <= $signed({3'd0, (a[30:23] == 8'h00) ? 8'd1 : a[30:23]})
                   - $signed({6'd0, lza});
      s1_eb_r   <= $signed({3'd0, (b[30:23] == 8'h00) ? 8'd1 : b[30:23]})
                   - $signed({6'd0, lzb});
      s1_side_r <= side_i;
    end
  end

  // Stage 2: significand product and exponent sum.
  logic               s2_vld_r;
  logic               s2_sign_r, s2_nan_r, s2_inf_r, s2_zero_r;
  logic [47:0]        s2_prod_r;
  logic signed [10:0] s2_er_r;
  logic [fisr_pkg::SIDE_W-1:0] s2_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (ena) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ena) begin
      s2_sign_r <= s1_sign_r;
      s2_nan_r  <= s1_nan_r;
      s2_inf_r  <= s1_inf_r;
      s2_zero_r <= s1_zero_r;
      s2_prod_r <= s1_ma_r * s1_mb_r;
      s2_er_r   <= s1_ea_r + s1_eb_r - 11'sd127;
      s2_side_r <= s1_side_r;
    end
  end

  // Stage 3: normalize and align for subnormal results.
  logic [47:0]        sig;
  logic signed [10:0] er;
  logic [5:0]         amt;
  logic [95:0]        ext;
  logic [7:0]         expf_nxt;
  logic [23:0]        mant_nxt;
  logic               grd_nxt, stk_nxt, ovf_nxt;

  always_comb begin
    if (s2_prod_r[47]) begin
      sig = s2_prod_r;
      er  = s2_er_r + 11'sd1;
    end else begin
      sig = {s2_prod_r[46:0], 1'b0};
      er  = s2_er_r;
    end
    ovf_nxt = (er >= 11'sd255);
    if (er < -11'sd62) begin
      amt = 6'd63;
    end else begin
      amt = 6'(11'sd1 - er);
    end
    ext = {sig, 48'd0} >> amt;
    if (er >= 11'sd1) begin
      expf_nxt = er[7:0];
      mant_nxt = sig[47:24];
      grd_nxt  = sig[23];
      stk_nxt  = |sig[22:0];
    end else begin
      expf_nxt = 8'd0;
      mant_nxt = ext[95:72];
      grd_nxt  = ext[71];
      stk_nxt  = (|ext[70:48]) | (|ext[47:0]);
    end
  end

  logic        s3_vld_r;
  logic        s3_sign_r, s3_nan_r, s3_inf_r, s3_zero_r;
  logic [7:0]  s3_expf_r;
  logic [22:0] s3_mant_r;
  logic        s3_grd_r, s3_stk_r;
  logic [fisr_pkg::SIDE_W-1:0] s3_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (ena) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ena) begin
      s3_sign_r <= s2_sign_r;
      s3_nan_r  <= s2_nan_r;
      s3_inf_r  <= s2_inf_r | (ovf_nxt & ~s2_zero_r);
      s3_zero_r <= s2_zero_r;
      s3_expf_r <= expf_nxt;
      s3_mant_r <= mant_nxt[22:0];
      s3_grd_r  <= grd_nxt;
      s3_stk_r  <= stk_nxt;
      s3_side_r <= s2_side_r;
    end
  end

  // Stage 4: rounding and packing.
  logic        s4_vld_r;
  logic [31:0] s4_res_r;
  logic [fisr_pkg::SIDE_W-1:0] s4_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (ena) begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ena) begin
      s4_res_r  <= fisr_pkg::round_pack(s3_sign_r, s3_nan_r, s3_inf_r, s3_zero_r,
                                        s3_expf_r, s3_mant_r, s3_grd_r, s3_stk_r);
      s4_side_r <= s3_side_r;
    end
  end

  assign out_vld = s4_vld_r;
  assign res     = s4_res_r;
  assign side_o  = s4_side_r;

endmodule

// File: hdl/fisr_fadd.sv
// ----------------------------------------------------------------------------
// fisr_fadd
// Four-stage binary32 adder, round to nearest-even, with a side bus.
// ----------------------------------------------------------------------------
module fisr_fadd (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        ena,
  input  logic                        in_vld,
  input  logic [31:0]                 a,
  input  logic [31:0]                 b,
  input  logic [fisr_pkg::SIDE_W-1:0] side_i,
  output logic                        out_vld,
  output logic [31:0]                 res,
  output logic [fisr_pkg::SIDE_W-1:0] side_o
);

  // Stage 1: classify, order by magnitude, exponent difference.
  logic        a_nan, a_inf, b_nan, b_inf, swap;
  logic [31:0] big, sml;
  logic [7:0]  eb_big, eb_sml;

  assign a_nan  = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
  assign a_inf  = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
  assign b_nan  = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
  assign b_inf  = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
  assign swap   = b[30:0] > a[30:0];
  assign big    = swap ? b : a;
  assign sml    = swap ? a : b;
  assign eb_big = (big[30:23] == 8'h00) ? 8'd1 : big[30:23];
  assign eb_sml = (sml[30:23] == 8'h00) ? 8'd1 : sml[30:23];

  logic        s1_vld_r;
  logic        s1_nan_r, s1_inf_r, s1_isgn_r, s1_sl_r, s1_ss_r;
  logic [7:0]  s1_el_r, s1_d_r;
  logic [23:0] s1_ml_r, s1_ms_r;
  logic [fisr_pkg::SIDE_W-1:0] s1_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (ena) begin
      s1_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ena) begin
      s1_nan_r  <= a_nan | b_nan | (a_inf & b_inf & (a[31] != b[31]));
      s1_inf_r  <= a_inf | b_inf;
      s1_isgn_r <= a_inf ? a[31] : b[31];
      s1_sl_r   <= big[31];
      s1_ss_r   <= sml[31];
      s1_el_r   <= eb_big;
      s1_d_r    <= eb_big - eb_sml;
      s1_ml_r   <= {big[30:23] != 8'h00, big[22:0]};
      s1_ms_r   <= {sml[30:23] != 8'h00, sml[22:0]};
      s1_side_r <= side_i;
    end
  end

  // Stage 2: align the smaller operand and add or subtract.
  logic [4:0]  amt;
  logic [53:0] ext;
  logic [26:0] al;
  logic [27:0] sum;

  always_comb begin
    amt = (s1_d_r > 8'd28) ? 5'd28 : s1_d_r[4:0];
    ext = {s1_ms_r, 3'd0, 27'd0} >> amt;
    al  = {ext[53:28], ext[27] | (|ext[26:0])};
    if (s1_sl_r == s1_ss_r) begin
      sum = {1'b0, s1_ml_r, 3'd0} + {1'b0, al};
    end else begin
      sum = {1'b0, s1_ml_r, 3'd0} - {1'b0, al};
    end
  end

  logic        s2_vld_r;
  logic        s2_nan_r, s2_inf_r, s2_isgn_r, s2_sign_r;
  logic [7:0]  s2_el_r;
  logic [27:0] s2_sum_r;
  logic [fisr_pkg::SIDE_W-1:0] s2_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (ena) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ena) begin
      s2_nan_r  <= s1_nan_r;
      s2_inf_r  <= s1_inf_r;
      s2_isgn_r <= s1_isgn_r;
      s2_sign_r <= (sum == 28'd0) ? (s1_sl_r & s1_ss_r) : s1_sl_r;
      s2_el_r   <= s1_el_r;
      s2_sum_r  <= sum;
      s2_side_r <= s1_side_r;
    end
  end

  // Stage 3: normalize, limited by the minimum exponent.
  logic [4:0]  lz, sh;
  logic [26:0] nrm;
  logic [8:0]  e;

  always_comb begin
    lz = fisr_pkg::lzc27(s2_sum_r[26:0]);
    sh = 5'd0;
    if (s2_sum_r[27]) begin
      nrm = {s2_sum_r[27:2], s2_sum_r[1] | s2_sum_r[0]};
      e   = {1'b0, s2_el_r} + 9'd1;
    end else begin
      sh  = ({4'd0, lz} > ({1'b0, s2_el_r} - 9'd1)) ? 5'(s2_el_r - 8'd1) : lz;
      nrm = s2_sum_r[26:0] << sh;
      e   = {1'b0, s2_el_r} - {4'd0, sh};
    end
  end

  logic        s3_vld_r;
  logic        s3_sign_r, s3_nan_r, s3_inf_r;
  logic [7:0]  s3_expf_r;
  logic [22:0] s3_mant_r;
  logic        s3_grd_r, s3_stk_r;
  logic [fisr_pkg::SIDE_W-1:0] s3_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (ena) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ena) begin
      s3_sign_r <= s2_inf_r ? s2_isgn_r : s2_sign_r;
      s3_nan_r  <= s2_nan_r;
      s3_inf_r  <= s2_inf_r | (e >= 9'd255);
      s3_expf_r <= nrm[26] ? e[7:0] : 8'd0;
      s3_mant_r <= nrm[25:3];
      s3_grd_r  <= nrm[2];
      s3_stk_r  <= nrm[1] | nrm[0];
      s3_side_r <= s2_side_r;
    end
  end

  // Stage 4: rounding and packing.
  logic        s4_vld_r;
  logic [31:0] s4_res_r;
  logic [fisr_pkg::SIDE_W-1:0] s4_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (ena) begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ena) begin
      s4_res_r  <= fisr_pkg::round_pack(s3_sign_r, s3_nan_r, s3_inf_r, 1'b0,
                                        s3_expf_r, s3_mant_r, s3_grd_r, s3_stk_r);
      s4_side_r <= s3_side_r;
    end
  end

  assign out_vld = s4_vld_r;
  assign res     = s4_res_r;
  assign side_o  = s4_side_r;

endmodule

// File: hdl/fast_inverse_square_root.sv
// ----------------------------------------------------------------------------
// fast_inverse_square_root
// Pipelined approximation of one over the square root of a binary32 value.
//
// The input channel carries a binary32 bit pattern on in_operand_bits and
// the result channel returns the approximation on out_result_bits, sign bit
// cleared and any NaN given as the canonical quiet NaN. Both channels use a
// valid and stall pair; a transfer happens on a clock edge with valid high
// and stall low.
// One operand is accepted every clock while the output is not stalled. From
// input transfer to the result on the output, an operand passes one four-stage
// multiply for the half value, then two Newton steps of four four-stage units
// each, and one output register.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_stall rises, so nothing is lost or repeated. Reset clears all valid
// bits; the pipeline is empty afterward.
// ----------------------------------------------------------------------------
module fast_inverse_square_root (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_operand_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_result_bits
);

  localparam int unsigned NS = fisr_pkg::NEWTON_STEPS;

  logic        ena;
  logic        out_valid_r;
  logic [31:0] out_result_bits_r;
  logic [31:0] shifted, guess;

  assign ena      = ~(out_valid_r & out_stall);
  assign in_stall = out_valid_r & out_stall;
  assign shifted  = {in_operand_bits[31], in_operand_bits[31:1]};
  assign guess    = fisr_pkg::GUESS_MAGIC - shifted;

  logic        st_vld  [NS+1];
  logic [31:0] st_y    [NS+1];
  logic [31:0] st_half [NS+1];
  logic [31:0] half_res;
  logic [fisr_pkg::SIDE_W-1:0] half_side;

  fisr_fmul u_half (
    .clk    (clk),
    .rst_n  (rst_n),
    .ena    (ena),
    .in_vld (in_valid),
    .a      (in_operand_bits),
    .b      (fisr_pkg::HALF_BITS),
    .side_i ({guess, 32'd0}),
    .out_vld(st_vld[0]),
    .res    (half_res),
    .side_o (half_side)
  );

  assign st_y[0]    = half_side[63:32];
  assign st_half[0] = half_res;

  for (genvar k = 0; k < NS; k++) begin : g_newton
    logic        v1, v2, v3;
    logic [31:0] r1, r2, r3, r4;
    logic [fisr_pkg::SIDE_W-1:0] sd1, sd2, sd3, sd4;

    fisr_fmul u_hy (
      .clk(clk), .rst_n(rst_n), .ena(ena),
      .in_vld(st_vld[k]), .a(st_half[k]), .b(st_y[k]),
      .side_i({st_y[k], st_half[k]}),
      .out_vld(v1), .res(r1), .side_o(sd1)
    );

    fisr_fmul u_hyy (
      .clk(clk), .rst_n(rst_n), .ena(ena),
      .in_vld(v1), .a(r1), .b(sd1[63:32]),
      .side_i(sd1),
      .out_vld(v2), .res(r2), .side_o(sd2)
    );

    fisr_fadd u_sub (
      .clk(clk), .rst_n(rst_n), .ena(ena),
      .in_vld(v2), .a(fisr_pkg::THREE_HALVES_BITS), .b({~r2[31], r2[30:0]}),
      .side_i(sd2),
      .out_vld(v3), .res(r3), .side_o(sd3)
    );

    fisr_fmul u_upd (
      .clk(clk), .rst_n(rst_n), .ena(ena),
      .in_vld(v3), .a(sd3[63:32]), .b(r3),
      .side_i(sd3),
      .out_vld(st_vld[k+1]), .res(r4), .side_o(sd4)
    );

    assign st_y[k+1]    = r4;
    assign st_half[k+1] = sd4[31:0];
  end

  logic [31:0] final_bits;

  always_comb begin
    final_bits = {1'b0, st_y[NS][30:0]};
    if ((final_bits[30:23] == 8'hff) && (final_bits[22:0] != 23'd0)) begin
      final_bits = fisr_pkg::CANON_QNAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ena) begin
      out_valid_r <= st_vld[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (ena) begin
      out_result_bits_r <= final_bits;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_bits = out_result_bits_r;

endmodule

// File: tb/fast_inverse_square_root_checker.sv
// ----------------------------------------------------------------------------
// fast_inverse_square_root_checker
// Watches both channels of the inverse square root block, predicts each result
// with a bit-exact binary32 model and compares the outputs in order.
// ----------------------------------------------------------------------------
module fast_inverse_square_root_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] in_operand_bits,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_result_bits,
  output int          mismatches,
  output int          outstanding,
  output int          results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0] expected_results[$];

  function automatic logic is_nan(input logic [31:0] v);
    return (v[30:23] == 8'hff) && (v[22:0] != 23'd0);
  endfunction

  function automatic logic is_inf(input logic [31:0] v);
    return (v[30:23] == 8'hff) && (v[22:0] == 23'd0);
  endfunction

  function automatic void unpack_f32(input logic [31:0] v, output logic [127:0] m,
                                     output int e);
    if (v[30:23] == 8'd0) begin
      m = {105'd0, v[22:0]};
      e = -149;
    end else begin
      m = {104'd0, 1'b1, v[22:0]};
      e = int'(v[30:23]) - 150;
    end
  endfunction

  // The value is mag * 2**e exactly; rounds it to nearest-even binary32.
  function automatic logic [31:0] round_f32(input logic sgn, input logic [127:0] mag,
                                            input int e);
    int p;
    int s;
    int bexp;
    logic [127:0] q;
    logic [127:0] rem;
    logic [127:0] halfway;
    if (mag == 128'd0) return {sgn, 31'd0};
    p = 127;
    while (!mag[p]) p--;
    bexp = p + e + 127;
    s = (bexp >= 1) ? p - 23 : -149 - e;
    if (s <= 0) begin
      q = mag << (-s);
    end else if (s >= 128) begin
      q = 128'd0;
    end else begin
      q = mag >> s;
      rem = mag & ((128'd1 << s) - 128'd1);
      halfway = 128'd1 << (s - 1);
      if (rem > halfway || (rem == halfway && q[0])) q = q + 128'd1;
    end
    if (bexp >= 1) begin
      if (q[24]) begin
        q = q >> 1;
        bexp++;
      end
      if (bexp >= 255) return {sgn, 8'hff, 23'd0};
      return {sgn, bexp[7:0], q[22:0]};
    end
    return {sgn, q[30:0]};
  endfunction

  function automatic logic [31:0] mul_f32(input logic [31:0] a, input logic [31:0] b);
    logic [127:0] ma;
    logic [127:0] mb;
    int ea;
    int eb;
    if (is_nan(a) || is_nan(b)) return fisr_pkg::CANON_QNAN;
    if (is_inf(a) || is_inf(b)) begin
      if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return fisr_pkg::CANON_QNAN;
      return {a[31] ^ b[31], 8'hff, 23'd0};
    end
    unpack_f32(a, ma, ea);
    unpack_f32(b, mb, eb);
    return round_f32(a[31] ^ b[31], ma * mb, ea + eb);
  endfunction

  function automatic logic [31:0] add_f32(input logic [31:0] a, input logic [31:0] b);
    logic [127:0] ma;
    logic [127:0] mb;
    logic [127:0] mag;
    logic [127:0] tm;
    int ea;
    int eb;
    int d;
    int te;
    logic sa;
    logic sb;
    logic sr;
    logic ts;
    if (is_nan(a) || is_nan(b)) return fisr_pkg::CANON_QNAN;
    if (is_inf(a) && is_inf(b)) return (a[31] != b[31]) ? fisr_pkg::CANON_QNAN : a;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    unpack_f32(a, ma, ea);
    unpack_f32(b, mb, eb);
    sa = a[31];
    sb = b[31];
    if (ea < eb) begin
      tm = ma; ma = mb; mb = tm;
      te = ea; ea = eb; eb = te;
      ts = sa; sa = sb; sb = ts;
    end
    d = ea - eb;
    if (d > 100) begin
      mb = (mb != 128'd0) ? 128'd1 : 128'd0;
      d = 100;
    end
    ma = ma << d;
    if (sa == sb) begin
      mag = ma + mb;
      sr = sa;
    end else if (ma >= mb) begin
      mag = ma - mb;
      sr = sa;
    end else begin
      mag = mb - ma;
      sr = sb;
    end
    if (mag == 128'd0) sr = sa & sb;
    return round_f32(sr, mag, ea - d);
  endfunction

  function automatic logic [31:0] predict_rsqrt(input logic [31:0] x);
    logic [31:0] half_x;
    logic [31:0] y;
    logic [31:0] t;
    half_x = mul_f32(x, fisr_pkg::HALF_BITS);
    y = fisr_pkg::GUESS_MAGIC - {x[31], x[31:1]};
    for (int i = 0; i < int'(fisr_pkg::NEWTON_STEPS); i++) begin
      t = mul_f32(half_x, y);
      t = mul_f32(t, y);
      t = add_f32(fisr_pkg::THREE_HALVES_BITS, {~t[31], t[30:0]});
      y = mul_f32(y, t);
    end
    y[31] = 1'b0;
    if (is_nan(y)) y = fisr_pkg::CANON_QNAN;
    return y;
  endfunction

  assign outstanding = expected_results.size();

  always_ff @(posedge clk) begin
    logic [31:0] exp_bits;
    if (!rst_n) begin
      mismatches <= 0;
      results_seen <= 0;
      expected_results.delete();
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_rsqrt(in_operand_bits));
      end
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          if (mismatches < 10) begin
            $display("Unexpected result transfer: result_bits=%h", out_result_bits);
          end
          mismatches <= mismatches + 1;
        end else begin
          exp_bits = expected_results.pop_front();
          if (exp_bits !== out_result_bits) begin
            if (mismatches < 10) begin
              $display("result_bits differs: expected %h, actual %h", exp_bits,
                       out_result_bits);
            end
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

endmodule

// File: tb/fast_inverse_square_root_tb.sv
// ----------------------------------------------------------------------------
// fast_inverse_square_root_tb
// Drives directed and random binary32 operands into the inverse square root
// block under varied idling and stalling, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module fast_inverse_square_root_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_operand_bits;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_result_bits;
  int          mismatches;
  int          outstanding;
  int          results_seen;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_cycles;
  int          cycle_count;
  int          operands_sent;

  fast_inverse_square_root i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operand_bits (in_operand_bits),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_bits (out_result_bits)
  );

  fast_inverse_square_root_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operand_bits (in_operand_bits),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_bits (out_result_bits),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_seen    (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // The receiver stalls at random, or without a break while a hold-off runs.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send_operand(input logic [31:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_operand_bits <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    operands_sent++;
    @(negedge clk);
  endtask

  function automatic logic [31:0] random_operand();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(9))
      0, 1, 2: v = v;
      3: v = {1'b0, 8'd0, v[22:0]};
      4: v = {v[31], 8'hff, v[22:0]};
      default: v = {1'b0, 8'($urandom_range(40, 214)), v[22:0]};
    endcase
    return v;
  endfunction

  task automatic drain_results();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  logic [31:0] directed_operands[$] = '{
    32'h00000000, 32'h80000000, 32'h3f800000, 32'h40800000, 32'h3e800000,
    32'h40000000, 32'h00000001, 32'h00000002, 32'h007fffff, 32'h00800000,
    32'h7f7fffff, 32'h7f800000, 32'hff800000, 32'h7fc00000, 32'h7f800001,
    32'hffffffff, 32'hbf800000, 32'h80000001, 32'h3fffffff, 32'h5f3759df,
    32'h7fffffff, 32'h80800000, 32'hfffffffe, 32'h55555555, 32'haaaaaaaa
  };

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operand_bits = 32'd0;
    out_stall = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    cycle_count = 0;
    operands_sent = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_operands[i]) send_operand(directed_operands[i]);
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 19 : 76) : 0;
      recv_stall_pct = (phase == 2) ? 76 : ((phase == 3) ? 19 : 0);
      if (phase == 0) hold_cycles <= 300;
      for (int n = 0; n < 460; n++) send_operand(random_operand());
      drain_results();
    end

    repeat (60) @(posedge clk);
    $display("Sent %0d operands (directed special values, then random under four",
             operands_sent);
    $display("idle and stall mixes with a long output hold-off); %0d results checked.",
             results_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
